FILE: hdl/tea_chained_block_cipher_top_macros.svh
// assertion macros shared by the cipher block
`ifndef TEA_CHAINED_BLOCK_CIPHER_TOP_MACROS_SVH
`define TEA_CHAINED_BLOCK_CIPHER_TOP_MACROS_SVH

`ifndef SYNTH
// plain property check on the rising clock edge, held off during reset
`define TCBC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tcbc check failed");
// condition in one cycle implies a result in the next
`define TCBC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tcbc next-cycle check failed");
`else
`define TCBC_ASSERT(label, clk, rst, prop)
`define TCBC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

FILE: hdl/tcbc_pkg.sv
package tcbc_pkg;

   // round constant of the cipher
   localparam logic [31:0] TCBC_DELTA = 32'h9e3779b9;

   localparam int BLOCK_WIDTH     = 64;
   localparam int WORD_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 3;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_A       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_B       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_C       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_D       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DECRYPT_MODE = 3'd4;

   // the four key words as one bundle
   typedef struct packed {
      logic [WORD_WIDTH-1:0] a;
      logic [WORD_WIDTH-1:0] b;
      logic [WORD_WIDTH-1:0] c;
      logic [WORD_WIDTH-1:0] d;
   } key_type;

   // half-round mixing function
   function automatic logic [WORD_WIDTH-1:0] tcbc_mix(
      input logic [WORD_WIDTH-1:0] v,
      input logic [WORD_WIDTH-1:0] sum,
      input logic [WORD_WIDTH-1:0] ka,
      input logic [WORD_WIDTH-1:0] kb
   );
      tcbc_mix = (v + sum) ^ ((v << 4) + ka) ^ ((v >> 5) + kb);
   endfunction

endpackage

FILE: hdl/tcbc_round_cell.sv
module tcbc_round_cell #(
   parameter logic [31:0] SUM_ENC = 32'h9e3779b9,
   parameter logic [31:0] SUM_DEC = 32'h9e3779b9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  tcbc_pkg::key_type key,
   input  logic              decrypt,
   input  logic              in_valid,
   input  logic [63:0]       in_data,
   output logic              out_valid,
   output logic [63:0]       out_data
);
   import tcbc_pkg::*;

   logic                  valid_ff;
   logic [63:0]           data_ff;
   logic [63:0]           data_in;
   logic [WORD_WIDTH-1:0] v0, v1;
   logic [WORD_WIDTH-1:0] e0, e1;
   logic [WORD_WIDTH-1:0] d0, d1;

   // one full round, both directions
   always_comb begin
      v0 = in_data[63:32];
      v1 = in_data[31:0];
      e0 = v0 + tcbc_mix(v1, SUM_ENC, key.a, key.b);
      e1 = v1 + tcbc_mix(e0, SUM_ENC, key.c, key.d);
      d1 = v1 - tcbc_mix(v0, SUM_DEC, key.c, key.d);
      d0 = v0 - tcbc_mix(d1, SUM_DEC, key.a, key.b);
      data_in = decrypt ? {d0, d1} : {e0, e1};
   end

   // hand the block on to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/tea_chained_block_cipher_top.sv
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tdata: data_block; tuser: first_block
// rsp       out  rsp_tvalid/rsp_tready  tdata: result_block
// csr       in   csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// a block passes through the ROUNDS round-cell registers to the result register,
// and the next block is taken only once the result is loaded, so one block is in
// flight at a time, set by the chaining loop through the row of round cells.
// reset clears keys, mode, chaining registers and all valid flags.
// a held result stalls the row only while a new result is waiting behind it.
`include "tea_chained_block_cipher_top_macros.svh"

module tea_chained_block_cipher_top #(
   parameter int ROUNDS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] data_block
   input  logic        req_tuser,   // [0] first_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] result_block
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [tcbc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import tcbc_pkg::*;

   key_type     key_ff;
   logic        decrypt_ff;
   logic [63:0] prev_result_ff;
   logic [63:0] prev_inner_ff;
   logic [63:0] mask_ff;
   logic [63:0] mask_in;
   logic        busy_ff;
   logic        out_valid_ff;
   logic [63:0] out_data_ff;

   logic        req_xfer;
   logic        advance;
   logic        finish;
   logic [63:0] chain_base;
   logic [63:0] block_x;
   logic [63:0] cipher_out;
   logic [63:0] result;

   logic              link_valid [ROUNDS+1];
   logic [63:0]       link_data  [ROUNDS+1];
   logic [ROUNDS-1:0] cell_valid;

   assign csr_ready  = 1'b1;
   assign req_tready = !busy_ff;
   assign req_xfer   = req_tvalid && req_tready;
   // the row holds only when the finished block cannot move into the result register
   assign advance    = !(link_valid[ROUNDS] && out_valid_ff && !rsp_tready);

   // whitening of the incoming block
   always_comb begin
      chain_base = req_tuser ? '0 : prev_result_ff;
      mask_in    = req_tuser ? '0 : prev_inner_ff;
      block_x    = req_tdata ^ chain_base;
   end

   assign link_valid[0] = req_xfer;
   assign link_data[0]  = block_x;

   // row of round cells
   for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
      localparam logic [31:0] SUM_E = 32'(64'(i + 1) * 64'(TCBC_DELTA));
      localparam logic [31:0] SUM_D = 32'(64'(ROUNDS - i) * 64'(TCBC_DELTA));
      tcbc_round_cell #(
         .SUM_ENC(SUM_E),
         .SUM_DEC(SUM_D)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .key      (key_ff),
         .decrypt  (decrypt_ff),
         .in_valid (link_valid[i]),
         .in_data  (link_data[i]),
         .out_valid(link_valid[i+1]),
         .out_data (link_data[i+1])
      );
      assign cell_valid[i] = link_valid[i+1];
   end

   assign cipher_out = link_data[ROUNDS];
   assign result     = cipher_out ^ mask_ff;
   assign finish     = link_valid[ROUNDS] && advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         decrypt_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_KEY_A:        key_ff.a   <= csr_data;
            REG_KEY_B:        key_ff.b   <= csr_data;
            REG_KEY_C:        key_ff.c   <= csr_data;
            REG_KEY_D:        key_ff.d   <= csr_data;
            REG_DECRYPT_MODE: decrypt_ff <= csr_data[0];
            default:          ;
         endcase
      end
   end

   // chaining registers and block tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_result_ff <= '0;
         prev_inner_ff  <= '0;
         busy_ff        <= 1'b0;
      end else begin
         if (req_xfer) begin
            busy_ff       <= 1'b1;
            prev_inner_ff <= decrypt_ff ? req_tdata : block_x;
            if (req_tuser) begin
               prev_result_ff <= '0;
            end
         end else if (finish) begin
            busy_ff        <= 1'b0;
            prev_result_ff <= decrypt_ff ? cipher_out : result;
         end
      end
      if (req_xfer) begin
         mask_ff <= mask_in;
      end
   end

   // result register toward the master side
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (finish) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // checks
   `TCBC_ASSERT(a_one_in_flight, clock, reset, $countones(cell_valid) <= 1)
   `TCBC_ASSERT(a_busy_matches_row, clock, reset, busy_ff == (cell_valid != '0))
   `TCBC_ASSERT_NEXT(a_enter_first_cell, clock, reset, req_xfer, cell_valid[0])
   `TCBC_ASSERT_NEXT(a_finish_shows, clock, reset, finish, rsp_tvalid && !busy_ff)

endmodule

FILE: verif/tea_chained_block_cipher_checker.sv
// watches the cipher channels, predicts each result block and compares it
module tea_chained_block_cipher_checker #(
   parameter int ROUNDS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] data_block
   input  logic        req_tuser,   // [0] first_block
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [63:0] result_block
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [tcbc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0] csr_data,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import tcbc_pkg::*;

   // predictor copy of the configuration and the chaining registers
   key_type     cipher_key;
   logic        decrypt_on;
   logic [63:0] chain_result;
   logic [63:0] chain_inner;

   logic [63:0] expected_blocks[$];
   logic [63:0] mixed_block;
   logic [63:0] plain_block;
   logic [63:0] predicted_block;
   logic [63:0] oldest_block;
   int          mismatch_count;

   // one half round of the feistel mix
   function automatic logic [31:0] half_round(
      input logic [31:0] v,
      input logic [31:0] sum,
      input logic [31:0] ka,
      input logic [31:0] kb
   );
      logic [31:0] shifted_up;
      logic [31:0] shifted_down;
      shifted_up   = {v[27:0], 4'b0000} + ka;
      shifted_down = {5'b00000, v[31:5]} + kb;
      return (v + sum) ^ shifted_up ^ shifted_down;
   endfunction

   function automatic logic [63:0] tea_encipher(input logic [63:0] blk, input key_type k);
      logic [31:0] left;
      logic [31:0] right;
      logic [31:0] sum;
      left  = blk[63:32];
      right = blk[31:0];
      sum   = '0;
      for (int r = 0; r < ROUNDS; r++) begin
         sum   = sum + TCBC_DELTA;
         left  = left + half_round(right, sum, k.a, k.b);
         right = right + half_round(left, sum, k.c, k.d);
      end
      return {left, right};
   endfunction

   function automatic logic [63:0] tea_decipher(input logic [63:0] blk, input key_type k);
      logic [31:0] left;
      logic [31:0] right;
      logic [31:0] sum;
      left  = blk[63:32];
      right = blk[31:0];
      sum   = 32'(ROUNDS) * TCBC_DELTA;
      for (int r = 0; r < ROUNDS; r++) begin
         right = right - half_round(left, sum, k.c, k.d);
         left  = left - half_round(right, sum, k.a, k.b);
         sum   = sum - TCBC_DELTA;
      end
      return {left, right};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cipher_key     = '0;
         decrypt_on     = 1'b0;
         chain_result   = '0;
         chain_inner    = '0;
         mismatch_count = 0;
         expected_blocks.delete();
      end else begin
         // register writes; unknown indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_KEY_A:        cipher_key.a = csr_data;
               REG_KEY_B:        cipher_key.b = csr_data;
               REG_KEY_C:        cipher_key.c = csr_data;
               REG_KEY_D:        cipher_key.d = csr_data;
               REG_DECRYPT_MODE: decrypt_on   = csr_data[0];
               default: ;
            endcase
         end

         // predict the result of an accepted block
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               chain_result = '0;
               chain_inner  = '0;
            end
            mixed_block = req_tdata ^ chain_result;
            if (decrypt_on) begin
               plain_block     = tea_decipher(mixed_block, cipher_key);
               predicted_block = plain_block ^ chain_inner;
               chain_result    = plain_block;
               chain_inner     = req_tdata;
            end else begin
               predicted_block = tea_encipher(mixed_block, cipher_key) ^ chain_inner;
               chain_result    = predicted_block;
               chain_inner     = mixed_block;
            end
            expected_blocks.push_back(predicted_block);
         end

         // compare each result transfer with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result block %h", rsp_tdata);
               mismatch_count++;
            end else begin
               oldest_block = expected_blocks.pop_front();
               if (rsp_tdata !== oldest_block) begin
                  if (mismatch_count < 10)
                     $display("result_block mismatch: expected %h, got %h",
                              oldest_block, rsp_tdata);
                  mismatch_count++;
               end
            end
         end
      end
      pending  <= expected_blocks.size();
      failures <= mismatch_count;
   end

endmodule

FILE: verif/tea_chained_block_cipher_top_tb.sv
module tea_chained_block_cipher_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcbc_pkg::*;

   localparam int ROUNDS        = 16;
   localparam int RANDOM_BLOCKS = 1150;
   localparam int STALL_LIMIT   = 2000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0] csr_data   = '0;

   int failures;
   int pending;
   int blocks_sent = 0;
   int quiet_cycles = 0;
   logic no_idle = 1'b0;

   always #4 clock = ~clock;

   tea_chained_block_cipher_top #(.ROUNDS(ROUNDS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tea_chained_block_cipher_checker #(.ROUNDS(ROUNDS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .failures   (failures),
      .pending    (pending)
   );

   // result side backpressure
   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= 27);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // key word with extremes mixed in
   function automatic logic [31:0] pick_key_word();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] pick_block();
      case ($urandom_range(19))
         0:       return 64'h0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // leaves csr_valid high so back-to-back writes need no lowering
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_key(input logic [31:0] ka, input logic [31:0] kb,
                          input logic [31:0] kc, input logic [31:0] kd,
                          input logic [31:0] mode_word);
      write_reg(REG_KEY_A, ka);
      write_reg(REG_KEY_B, kb);
      write_reg(REG_KEY_C, kc);
      write_reg(REG_KEY_D, kd);
      write_reg(REG_DECRYPT_MODE, mode_word);
      csr_valid <= 1'b0;
   endtask

   // block transfer with an optional gap in front
   task automatic send_block(input logic [63:0] blk, input logic first);
      int gap;
      if (!no_idle && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(4, 1);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= blk;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      blocks_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int target;
      int phase_len;
      int msg_len;
      int phase_sent;
      logic first;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero key, encrypt, field extremes
      set_key(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_block(64'h0, 1'b1);
      send_block('1, 1'b0);
      send_block(64'h8000_0000_0000_0000, 1'b0);
      send_block(64'h1, 1'b0);
      send_block(64'h0123_4567_89ab_cdef, 1'b1);
      drain();

      // all-ones key, decrypt
      set_key('1, '1, '1, '1, 32'hffff_ffff);
      send_block(64'h0, 1'b1);
      send_block('1, 1'b0);
      send_block(64'hfedc_ba98_7654_3210, 1'b0);
      drain();

      // mode change within a message, wide mode values, unknown indexes
      write_reg(REG_DECRYPT_MODE, 32'hffff_fffe);
      write_reg(3'd5, 32'hffff_ffff);
      write_reg(3'd6, 32'h1234_5678);
      write_reg(3'd7, 32'h0000_0001);
      csr_valid <= 1'b0;
      send_block(64'hdead_beef_cafe_f00d, 1'b0);
      send_block('1, 1'b0);
      drain();
      write_reg(REG_DECRYPT_MODE, 32'h0000_0003);
      csr_valid <= 1'b0;
      send_block(64'h5555_5555_5555_5555, 1'b0);
      send_block(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
      drain();

      // ordinary key, a message each way
      set_key(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210, 32'h0);
      send_block(64'h0011_2233_4455_6677, 1'b1);
      send_block(64'h8899_aabb_ccdd_eeff, 1'b0);
      send_block(64'h0, 1'b0);
      send_block(64'h7fff_ffff_ffff_ffff, 1'b0);
      drain();
      write_reg(REG_DECRYPT_MODE, 32'h1);
      csr_valid <= 1'b0;
      send_block(64'h0011_2233_4455_6677, 1'b1);
      send_block(64'h8899_aabb_ccdd_eeff, 1'b0);
      send_block(64'h0, 1'b0);
      drain();

      // random phases of messages under random settings
      target = blocks_sent + RANDOM_BLOCKS;
      while (blocks_sent < target) begin
         for (int idx = 0; idx < 8; idx++) begin
            if ($urandom_range(99) < 60)
               write_reg(idx[CSR_INDEX_WIDTH-1:0],
                         (idx == REG_DECRYPT_MODE) ? $urandom : pick_key_word());
         end
         csr_valid <= 1'b0;
         phase_len  = $urandom_range(110, 30);
         phase_sent = 0;
         while (phase_sent < phase_len) begin
            msg_len = $urandom_range(12, 1);
            for (int j = 0; j < msg_len; j++) begin
               no_idle <= (blocks_sent >= target - 700) && (blocks_sent < target - 500);
               // mostly proper messages, some stray or missing first marks
               if ($urandom_range(99) < 10)
                  first = $urandom_range(1);
               else
                  first = (j == 0);
               send_block(pick_block(), first);
               phase_sent++;
            end
         end
         drain();
      end

      repeat (ROUNDS + 8) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
